// ===== sv/generational_handle_slot_table_assert.svh =====
// ============================================================================
// Generational handle slot table: assertion macros
// Concurrent assertion shorthands used by the slot table RTL. They expand to
// nothing when SYNTHESIS is defined.
// ============================================================================
`ifndef GENERATIONAL_HANDLE_SLOT_TABLE_ASSERT_SVH
`define GENERATIONAL_HANDLE_SLOT_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define GHST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot table assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GHST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot table assertion failed");

`else

`define GHST_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GHST_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/ghst_pkg.sv =====
// ============================================================================
// Generational handle slot table package
// Sizes, command and status codes, and the free slot search.
// ============================================================================
package ghst_pkg;

    // Table geometry.
    localparam int SLOT_COUNT = 64;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Word field widths.
    localparam int HANDLE_W = 32;
    localparam int GEN_W    = 32;
    localparam int IDX_W    = 7;

    // Command codes.
    typedef enum logic [1:0] {
        OP_ALLOCATE    = 2'd0,
        OP_RELEASE     = 2'd1,
        OP_VALIDATE    = 2'd2,
        OP_RELEASE_ALL = 2'd3
    } t_opcode;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef logic [SLOT_COUNT-1:0] t_slot_vec;
    typedef logic [SLOT_W-1:0]     t_slot_addr;

    // Lowest clear bit of the live vector; zero when every slot is live.
    function automatic t_slot_addr find_free(input t_slot_vec live);
        t_slot_addr res;
        res = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!live[i]) begin
                res = SLOT_W'(i);
            end
        end
        return res;
    endfunction

endpackage

// ===== sv/generational_handle_slot_table.sv =====
// ============================================================================
// Generational handle slot table
// Allocates, releases and validates handles made of a slot number plus one
// and the generation of that slot.
// ============================================================================
// Usage:
//   Command channel: drive i_opcode, i_handle_index and i_handle_generation
//   with start high; the word is taken at the rising edge where busy is low.
//   busy is always low, so a command can be issued in every cycle.
//   Result channel: o_strobe is high for one cycle with o_status,
//   o_result_index and o_result_generation. The receiver cannot stall it.
//   Flow: the RAM is read at the command edge, then the check stage checks
//   the handle and updates the table, and the result word is registered
//   into the result registers. Throughput is one command per cycle.
//   Generations live in a RAM; live bits, a written bit and a pending
//   increment bit per slot live in flip-flops. Release-all only moves the live
//   bits into the pending bits, which are folded into the RAM on the next
//   allocate of that slot.
//   Reset clears every live, written and pending bit, so the table comes up
//   empty with all generations zero and is ready in the cycle after reset.
// ============================================================================
`include "generational_handle_slot_table_assert.svh"

module generational_handle_slot_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_opcode,
    input  logic [ghst_pkg::HANDLE_W-1:0] i_handle_index,
    input  logic [ghst_pkg::GEN_W-1:0]    i_handle_generation,
    output logic                          o_strobe,
    output logic [1:0]                    o_status,
    output logic [ghst_pkg::IDX_W-1:0]    o_result_index,
    output logic [ghst_pkg::GEN_W-1:0]    o_result_generation
);

    // Slot state.
    ghst_pkg::t_slot_vec  r_live, n_live;
    ghst_pkg::t_slot_vec  r_pend, n_pend;
    ghst_pkg::t_slot_vec  r_wr, n_wr;

    // Check stage registers.
    logic                            r_s1_valid;
    ghst_pkg::t_opcode               r_op;
    logic [ghst_pkg::HANDLE_W-1:0]   r_idx;
    logic [ghst_pkg::GEN_W-1:0]      r_gen;
    ghst_pkg::t_slot_addr            r_addr;
    logic                            r_full;
    logic                            r_byp;
    logic [ghst_pkg::GEN_W-1:0]      r_byp_data;

    // Result registers.
    logic                            r_out_valid;
    ghst_pkg::t_status               r_status, n_status;
    logic [ghst_pkg::IDX_W-1:0]      r_res_idx, n_res_idx;
    logic [ghst_pkg::GEN_W-1:0]      r_res_gen, n_res_gen;

    // Command side.
    logic                            acc;
    ghst_pkg::t_slot_addr            rd_addr;
    logic [ghst_pkg::HANDLE_W-1:0]   idx_m1;
    logic                            n_byp;

    // Check stage logic.
    logic [ghst_pkg::GEN_W-1:0]      ram_rdata;
    logic [ghst_pkg::GEN_W-1:0]      s1_base;
    logic [ghst_pkg::GEN_W-1:0]      s1_gen;
    logic                            s1_in_range;
    logic                            s1_hit;
    logic [ghst_pkg::HANDLE_W-1:0]   s1_idx_p1;
    logic                            s1_we;
    logic [ghst_pkg::GEN_W-1:0]      s1_wdata;

    assign busy = 1'b0;
    assign acc  = start && !busy;

    // Generation store.
    ghst_ram #(
        .WIDTH (ghst_pkg::GEN_W),
        .DEPTH (ghst_pkg::SLOT_COUNT)
    ) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (s1_we),
        .i_waddr (r_addr),
        .i_wdata (s1_wdata),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // Effective generation of the addressed slot, with forwarding of the
    // write made by the previous command and the pending release-all step.
    always_comb begin
        if (r_byp) begin
            s1_base = r_byp_data;
        end else if (r_wr[r_addr]) begin
            s1_base = ram_rdata;
        end else begin
            s1_base = '0;
        end
        s1_gen      = s1_base + ghst_pkg::GEN_W'(r_pend[r_addr]);
        s1_in_range = (r_idx != '0) &&
                      (r_idx <= ghst_pkg::HANDLE_W'(ghst_pkg::SLOT_COUNT));
        s1_hit      = s1_in_range && r_live[r_addr] && (s1_gen == r_gen);
        s1_idx_p1   = ghst_pkg::HANDLE_W'(r_addr) + ghst_pkg::HANDLE_W'(1);
    end

    // Command execution: next slot state, RAM write and result word.
    always_comb begin
        n_live    = r_live;
        n_pend    = r_pend;
        n_wr      = r_wr;
        s1_we     = 1'b0;
        s1_wdata  = s1_gen;
        n_status  = ghst_pkg::ST_OK;
        n_res_idx = '0;
        n_res_gen = '0;
        if (r_s1_valid) begin
            case (r_op)
                ghst_pkg::OP_ALLOCATE: begin
                    if (r_full) begin
                        n_status = ghst_pkg::ST_FULL;
                    end else begin
                        n_live[r_addr] = 1'b1;
                        n_pend[r_addr] = 1'b0;
                        n_wr[r_addr]   = 1'b1;
                        s1_we          = 1'b1;
                        s1_wdata       = s1_gen;
                        n_res_idx      = s1_idx_p1[ghst_pkg::IDX_W-1:0];
                        n_res_gen      = s1_gen;
                    end
                end
                ghst_pkg::OP_RELEASE: begin
                    if (s1_hit) begin
                        n_live[r_addr] = 1'b0;
                        n_wr[r_addr]   = 1'b1;
                        s1_we          = 1'b1;
                        s1_wdata       = s1_gen + ghst_pkg::GEN_W'(1);
                    end else begin
                        n_status = ghst_pkg::ST_INVALID;
                    end
                end
                ghst_pkg::OP_VALIDATE: begin
                    if (s1_hit) begin
                        n_res_idx = r_idx[ghst_pkg::IDX_W-1:0];
                        n_res_gen = s1_gen;
                    end else begin
                        n_status = ghst_pkg::ST_INVALID;
                    end
                end
                ghst_pkg::OP_RELEASE_ALL: begin
                    n_pend = r_pend | r_live;
                    n_live = '0;
                end
                default: begin
                    n_status = ghst_pkg::ST_INVALID;
                end
            endcase
        end
    end

    // RAM read address for the incoming word: lowest free slot after the
    // command now in the check stage, or the slot named by the handle.
    always_comb begin
        idx_m1 = i_handle_index - ghst_pkg::HANDLE_W'(1);
        if (ghst_pkg::t_opcode'(i_opcode) == ghst_pkg::OP_ALLOCATE) begin
            rd_addr = ghst_pkg::find_free(n_live);
        end else begin
            rd_addr = idx_m1[ghst_pkg::SLOT_W-1:0];
        end
        n_byp = s1_we && (r_addr == rd_addr);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= '0;
            r_pend      <= '0;
            r_wr        <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_live      <= n_live;
            r_pend      <= n_pend;
            r_wr        <= n_wr;
            r_s1_valid  <= acc;
            r_out_valid <= r_s1_valid;
        end
    end

    // Command and result payload.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op       <= ghst_pkg::t_opcode'(i_opcode);
            r_idx      <= i_handle_index;
            r_gen      <= i_handle_generation;
            r_addr     <= rd_addr;
            r_full     <= &n_live;
            r_byp      <= n_byp;
            r_byp_data <= s1_wdata;
        end
        r_status  <= n_status;
        r_res_idx <= n_res_idx;
        r_res_gen <= n_res_gen;
    end

    assign o_strobe            = r_out_valid;
    assign o_status            = r_status;
    assign o_result_index      = r_res_idx;
    assign o_result_generation = r_res_gen;

    // Every word in the check stage yields exactly one result in the next cycle.
    `GHST_ASSERT_NXT(a_check_to_result, i_clk, i_rst_n, r_s1_valid, r_out_valid)
    `GHST_ASSERT_NXT(a_no_stray_result, i_clk, i_rst_n, !r_s1_valid, !r_out_valid)

    // A table-full result means every slot is still live.
    `GHST_ASSERT_IMP(a_full_all_live, i_clk, i_rst_n,
        r_out_valid && (r_status == ghst_pkg::ST_FULL), &r_live)

    // A pending generation step only exists on a free slot.
    `GHST_ASSERT_IMP(a_pend_not_live, i_clk, i_rst_n, 1'b1, (r_pend & r_live) == '0)

    // Release-all leaves no live slot.
    `GHST_ASSERT_NXT(a_release_all_clears, i_clk, i_rst_n,
        r_s1_valid && (r_op == ghst_pkg::OP_RELEASE_ALL), r_live == '0)

endmodule

// ===== sv/ghst_ram.sv =====
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ============================================================================
module ghst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule
